[rtl/brace_keyvalue_tokenizer_top_defines.svh]
// assertion macros used by the tokenizer checker
`ifndef BRACE_KEYVALUE_TOKENIZER_TOP_DEFINES_SVH
`define BRACE_KEYVALUE_TOKENIZER_TOP_DEFINES_SVH

// property checked on every clock while out of reset
`define BKVT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every clock, reset included
`define BKVT_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/bkvt_pkg.sv]
// types, codes and byte constants of the key/value tokenizer
package bkvt_pkg;

    // scanner state, one-hot
    typedef enum logic [5:0] {
        M_BETWEEN = 6'b000001,
        M_SLASH   = 6'b000010,
        M_COMMENT = 6'b000100,
        M_STRING  = 6'b001000,
        M_ESCAPE  = 6'b010000,
        M_WORD    = 6'b100000
    } mode_t;

    typedef enum logic [2:0] {
        ROLE_SKIP    = 3'd0,
        ROLE_WORD    = 3'd1,
        ROLE_OPENQ   = 3'd2,
        ROLE_CONTENT = 3'd3,
        ROLE_CLOSEQ  = 3'd4,
        ROLE_OPENB   = 3'd5,
        ROLE_CLOSEB  = 3'd6,
        ROLE_END     = 3'd7
    } role_t;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // result queue
    localparam int RES_DEPTH = 4;
    localparam int RES_AW    = $clog2(RES_DEPTH);
    localparam int RES_CW    = $clog2(RES_DEPTH + 1);

    typedef struct packed {
        logic [7:0] out_byte;
        role_t      role;
        logic       token_first;
        logic       last_of_run;
    } result_t;

    // everything one request produces
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
        mode_t      next_mode;
    } dec_t;

endpackage

[rtl/bkvt_in_if.sv]
// request channel: text byte and end marker
interface bkvt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_marker;

    modport source (output valid, output in_byte, output end_marker, input ready);
    modport sink (input valid, input in_byte, input end_marker, output ready);
endinterface

[rtl/bkvt_out_if.sv]
// result channel: classified byte and its role
interface bkvt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [2:0] role;
    logic       token_first;
    logic       last_of_run;

    modport source (output valid, output out_byte, output role, output token_first,
                    output last_of_run, input ready);
    modport sink (input valid, input out_byte, input role, input token_first,
                  input last_of_run, output ready);
endinterface

[rtl/bkvt_decode.sv]
// per-byte classification and next scanner state
module bkvt_decode (
    input  logic [7:0]     in_byte,
    input  logic           end_marker,
    input  bkvt_pkg::mode_t mode,
    output bkvt_pkg::dec_t dec
);
    import bkvt_pkg::*;

    function automatic result_t mk(input logic [7:0] b, input role_t r, input logic f);
        result_t t;
        t.out_byte    = b;
        t.role        = r;
        t.token_first = f;
        t.last_of_run = 1'b0;
        return t;
    endfunction

    logic    is_sp;
    result_t wb_res;
    mode_t   wb_mode;
    dec_t    d;

    assign is_sp = (in_byte == CH_SPACE) || (in_byte >= CH_TAB && in_byte <= CH_CR);

    // byte that continues a word
    always_comb
    begin
        if (is_sp)
        begin
            wb_res  = mk(in_byte, ROLE_SKIP, 1'b0);
            wb_mode = M_BETWEEN;
        end
        else if (in_byte == CH_LBRACE)
        begin
            wb_res  = mk(in_byte, ROLE_OPENB, 1'b1);
            wb_mode = M_BETWEEN;
        end
        else if (in_byte == CH_RBRACE)
        begin
            wb_res  = mk(in_byte, ROLE_CLOSEB, 1'b1);
            wb_mode = M_BETWEEN;
        end
        else
        begin
            wb_res  = mk(in_byte, ROLE_WORD, 1'b0);
            wb_mode = M_WORD;
        end
    end

    always_comb
    begin
        d.count     = 2'd1;
        d.r0        = mk(in_byte, ROLE_SKIP, 1'b0);
        d.r1        = mk(8'h00, ROLE_END, 1'b0);
        d.next_mode = mode;
        if (end_marker)
        begin
            d.next_mode = M_BETWEEN;
            if (mode == M_SLASH)
            begin
                d.count = 2'd2;
                d.r0    = mk(CH_SLASH, ROLE_WORD, 1'b1);
            end
            else
            begin
                d.r0 = mk(8'h00, ROLE_END, 1'b0);
            end
        end
        else
        begin
            case (mode)
                M_SLASH:
                begin
                    d.count = 2'd2;
                    if (in_byte == CH_SLASH)
                    begin
                        d.r0        = mk(CH_SLASH, ROLE_SKIP, 1'b0);
                        d.r1        = mk(in_byte, ROLE_SKIP, 1'b0);
                        d.next_mode = M_COMMENT;
                    end
                    else
                    begin
                        d.r0        = mk(CH_SLASH, ROLE_WORD, 1'b1);
                        d.r1        = wb_res;
                        d.next_mode = wb_mode;
                    end
                end
                M_COMMENT:
                begin
                    if (in_byte == CH_LF)
                        d.next_mode = M_BETWEEN;
                end
                M_STRING:
                begin
                    if (in_byte == CH_QUOTE)
                    begin
                        d.r0        = mk(in_byte, ROLE_CLOSEQ, 1'b0);
                        d.next_mode = M_BETWEEN;
                    end
                    else
                    begin
                        d.r0 = mk(in_byte, ROLE_CONTENT, 1'b0);
                        if (in_byte == CH_BSLASH)
                            d.next_mode = M_ESCAPE;
                    end
                end
                M_ESCAPE:
                begin
                    d.r0        = mk(in_byte, ROLE_CONTENT, 1'b0);
                    d.next_mode = M_STRING;
                end
                M_WORD:
                begin
                    d.r0        = wb_res;
                    d.next_mode = wb_mode;
                end
                default:
                begin
                    d.next_mode = M_BETWEEN;
                    if (is_sp)
                        d.r0 = mk(in_byte, ROLE_SKIP, 1'b0);
                    else if (in_byte == CH_SLASH)
                    begin
                        // hold the slash until the next byte shows a comment or a word
                        d.count     = 2'd0;
                        d.next_mode = M_SLASH;
                    end
                    else if (in_byte == CH_LBRACE)
                        d.r0 = mk(in_byte, ROLE_OPENB, 1'b1);
                    else if (in_byte == CH_RBRACE)
                        d.r0 = mk(in_byte, ROLE_CLOSEB, 1'b1);
                    else if (in_byte == CH_QUOTE)
                    begin
                        d.r0        = mk(in_byte, ROLE_OPENQ, 1'b1);
                        d.next_mode = M_STRING;
                    end
                    else
                    begin
                        d.r0        = mk(in_byte, ROLE_WORD, 1'b1);
                        d.next_mode = M_WORD;
                    end
                end
            endcase
        end
        d.r0.last_of_run = (d.count == 2'd1);
        d.r1.last_of_run = 1'b1;
    end

    assign dec = d;

endmodule

[rtl/brace_keyvalue_tokenizer_top.sv]
// key/value text tokenizer top level: scanner state and result queue
//
//  channel   dir  payload                                    accepted when
//  tok_in    in   in_byte[7:0], end_marker                   valid && ready
//  tok_out   out  out_byte[7:0], role[2:0], token_first,     valid && ready
//                 last_of_run
//
// one request per clock while ready; its results go into a four-entry result queue
// a request giving two results needs two transfers on tok_out, which sets the long-run rate
// tok_in.ready is high while the queue has room for two results
// reset clears the scanner state and empties the queue; no clearing pass
module brace_keyvalue_tokenizer_top (
    input logic      clk,
    input logic      rst_n,
    bkvt_in_if.sink  tok_in,
    bkvt_out_if.source tok_out
);
    import bkvt_pkg::*;

    mode_t             mode_reg, mode_next;
    logic [RES_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RES_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RES_CW-1:0] count_reg, count_next;
    result_t           res_mem [RES_DEPTH];
    dec_t              dec;
    logic              in_fire;
    logic              out_fire;
    logic [1:0]        push_n;
    result_t           head;

    bkvt_decode u_decode (
        .in_byte    (tok_in.in_byte),
        .end_marker (tok_in.end_marker),
        .mode       (mode_reg),
        .dec        (dec)
    );

    assign tok_in.ready = (count_reg <= RES_CW'(RES_DEPTH - 2));
    assign in_fire      = tok_in.valid && tok_in.ready;
    assign out_fire     = tok_out.valid && tok_out.ready;
    assign push_n       = in_fire ? dec.count : 2'd0;

    always_comb
    begin
        mode_next   = in_fire ? dec.next_mode : mode_reg;
        wr_ptr_next = wr_ptr_reg + RES_AW'(push_n);
        rd_ptr_next = rd_ptr_reg + RES_AW'(out_fire);
        count_next  = count_reg + RES_CW'(push_n) - RES_CW'(out_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_BETWEEN;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            res_mem[wr_ptr_reg] <= dec.r0;
        if (push_n == 2'd2)
            res_mem[wr_ptr_reg + RES_AW'(1)] <= dec.r1;
    end

    assign head                = res_mem[rd_ptr_reg];
    assign tok_out.valid       = (count_reg != '0);
    assign tok_out.out_byte    = head.out_byte;
    assign tok_out.role        = head.role;
    assign tok_out.token_first = head.token_first;
    assign tok_out.last_of_run = head.last_of_run;

endmodule

[rtl/bkvt_checker.sv]
// port-level checks of the tokenizer top level, bound into it
`include "brace_keyvalue_tokenizer_top_defines.svh"

module bkvt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic [2:0] role,
    input logic       token_first,
    input logic       last_of_run
);
    import bkvt_pkg::*;

    logic        out_stall;
    logic        out_fire;
    logic        is_end;
    logic [12:0] out_payload;

    assign out_stall   = out_valid && !out_ready;
    assign out_fire    = out_valid && out_ready;
    assign is_end      = out_valid && (role == ROLE_END);
    assign out_payload = {out_byte, role, token_first, last_of_run};

    // a stalled result stays put
    `BKVT_ASSERT(a_out_hold, out_stall |=> out_valid && $stable(out_payload), "stalled result changed")

    // the second result of a request is already queued with the first
    `BKVT_ASSERT(a_pair_follows, out_fire && !last_of_run |=> out_valid, "missing second result")

    // the end result is a bare zero byte closing its request
    `BKVT_ASSERT(a_end_shape, is_end |-> last_of_run && !token_first && (out_byte == '0), "bad end result")

    // nothing is offered right out of reset
    `BKVT_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "result offered after reset")

endmodule

bind brace_keyvalue_tokenizer_top bkvt_checker u_bkvt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (tok_out.valid),
    .out_ready   (tok_out.ready),
    .out_byte    (tok_out.out_byte),
    .role        (tok_out.role),
    .token_first (tok_out.token_first),
    .last_of_run (tok_out.last_of_run)
);

[tb/tb_top.sv]
// testbench for the key/value text tokenizer: directed table, then random text, checked per result
`timescale 1ns / 1ps

module tb_top;
    import bkvt_pkg::*;

    localparam int RANDOM_ITEMS = 1500;
    localparam int PHASE_ITEMS  = RANDOM_ITEMS / 3;
    localparam int TAIL_CYCLES  = 16;
    localparam int STALL_LIMIT  = 5000;
    localparam int REPORT_MAX   = 10;

    typedef struct {
        logic [7:0] b;
        logic       eom;
        bit         typed;
        int         n_typed;
        result_t    t0;
        result_t    t1;
    } text_req_t;

    logic clk;
    logic rst_n;

    bkvt_in_if  in_ch ();
    bkvt_out_if out_ch ();

    brace_keyvalue_tokenizer_top uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .tok_in  (in_ch),
        .tok_out (out_ch)
    );

    text_req_t text_q[$];
    text_req_t cur_req;
    result_t   pending_tokens[$];
    mode_t     scan_state;
    int        mismatches;
    int        send_idle;
    int        recv_idle;
    int        stall_cycles;
    int        n_directed;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic result_t tok(logic [7:0] b, role_t ro, logic first, logic last);
        result_t r;
        r.out_byte    = b;
        r.role        = ro;
        r.token_first = first;
        r.last_of_run = last;
        return r;
    endfunction

    function automatic bit is_blank(logic [7:0] b);
        return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
    endfunction

    // byte that follows a word byte: whitespace or a brace closes the word
    function automatic result_t word_next(logic [7:0] b);
        result_t r;
        if (is_blank(b))
        begin
            r = tok(b, ROLE_SKIP, 1'b0, 1'b0);
            scan_state = M_BETWEEN;
        end
        else if (b == CH_LBRACE)
        begin
            r = tok(b, ROLE_OPENB, 1'b1, 1'b0);
            scan_state = M_BETWEEN;
        end
        else if (b == CH_RBRACE)
        begin
            r = tok(b, ROLE_CLOSEB, 1'b1, 1'b0);
            scan_state = M_BETWEEN;
        end
        else
        begin
            r = tok(b, ROLE_WORD, 1'b0, 1'b0);
            scan_state = M_WORD;
        end
        return r;
    endfunction

    function automatic void classify_byte(input logic [7:0] b, input logic eom, output int n,
                                          output result_t r0, output result_t r1);
        n  = 0;
        r0 = '0;
        r1 = '0;
        if (eom)
        begin
            // a held slash goes out as a one-byte word ahead of the end result
            if (scan_state == M_SLASH)
            begin
                r0 = tok(CH_SLASH, ROLE_WORD, 1'b1, 1'b0);
                r1 = tok(8'h00, ROLE_END, 1'b0, 1'b0);
                n  = 2;
            end
            else
            begin
                r0 = tok(8'h00, ROLE_END, 1'b0, 1'b0);
                n  = 1;
            end
            scan_state = M_BETWEEN;
        end
        else
        begin
            case (scan_state)
                M_SLASH:
                begin
                    n = 2;
                    if (b == CH_SLASH)
                    begin
                        r0 = tok(CH_SLASH, ROLE_SKIP, 1'b0, 1'b0);
                        r1 = tok(b, ROLE_SKIP, 1'b0, 1'b0);
                        scan_state = M_COMMENT;
                    end
                    else
                    begin
                        r0 = tok(CH_SLASH, ROLE_WORD, 1'b1, 1'b0);
                        r1 = word_next(b);
                    end
                end
                M_COMMENT:
                begin
                    r0 = tok(b, ROLE_SKIP, 1'b0, 1'b0);
                    n  = 1;
                    if (b == CH_LF)
                        scan_state = M_BETWEEN;
                end
                M_STRING:
                begin
                    n = 1;
                    if (b == CH_QUOTE)
                    begin
                        r0 = tok(b, ROLE_CLOSEQ, 1'b0, 1'b0);
                        scan_state = M_BETWEEN;
                    end
                    else
                    begin
                        r0 = tok(b, ROLE_CONTENT, 1'b0, 1'b0);
                        if (b == CH_BSLASH)
                            scan_state = M_ESCAPE;
                    end
                end
                M_ESCAPE:
                begin
                    r0 = tok(b, ROLE_CONTENT, 1'b0, 1'b0);
                    n  = 1;
                    scan_state = M_STRING;
                end
                M_WORD:
                begin
                    r0 = word_next(b);
                    n  = 1;
                end
                default:
                begin
                    scan_state = M_BETWEEN;
                    n = 1;
                    if (is_blank(b))
                        r0 = tok(b, ROLE_SKIP, 1'b0, 1'b0);
                    else if (b == CH_SLASH)
                    begin
                        n = 0;
                        scan_state = M_SLASH;
                    end
                    else if (b == CH_LBRACE)
                        r0 = tok(b, ROLE_OPENB, 1'b1, 1'b0);
                    else if (b == CH_RBRACE)
                        r0 = tok(b, ROLE_CLOSEB, 1'b1, 1'b0);
                    else if (b == CH_QUOTE)
                    begin
                        r0 = tok(b, ROLE_OPENQ, 1'b1, 1'b0);
                        scan_state = M_STRING;
                    end
                    else
                    begin
                        r0 = tok(b, ROLE_WORD, 1'b1, 1'b0);
                        scan_state = M_WORD;
                    end
                end
            endcase
        end
        if (n == 1)
            r0.last_of_run = 1'b1;
        else if (n == 2)
            r1.last_of_run = 1'b1;
    endfunction

    task automatic add_typed(logic [7:0] b, logic eom, int n, result_t t0, result_t t1);
        text_req_t q;
        q.b       = b;
        q.eom     = eom;
        q.typed   = 1'b1;
        q.n_typed = n;
        q.t0      = t0;
        q.t1      = t1;
        text_q.push_back(q);
    endtask

    task automatic add_row(logic [7:0] b, logic eom);
        text_req_t q;
        q.b       = b;
        q.eom     = eom;
        q.typed   = 1'b0;
        q.n_typed = 0;
        q.t0      = '0;
        q.t1      = '0;
        text_q.push_back(q);
    endtask

    // mostly well-formed tokens with random content, some noise and broken pieces
    task automatic add_random_chunk();
        int         roll;
        int         len;
        logic [7:0] b;
        roll = $urandom_range(99);
        if (roll < 25)
        begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
            begin
                do
                    b = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(8'h21, 8'h7E));
                while (is_blank(b) || b == CH_LBRACE || b == CH_RBRACE);
                add_row(b, 1'b0);
            end
        end
        else if (roll < 40)
        begin
            add_row(CH_QUOTE, 1'b0);
            len = $urandom_range(0, 6);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(4) == 0)
                begin
                    add_row(CH_BSLASH, 1'b0);
                    add_row(($urandom_range(2) == 0) ? CH_QUOTE : 8'($urandom), 1'b0);
                end
                else
                begin
                    do
                        b = 8'($urandom);
                    while (b == CH_QUOTE || b == CH_BSLASH);
                    add_row(b, 1'b0);
                end
            end
            if ($urandom_range(9) != 0)
                add_row(CH_QUOTE, 1'b0);
        end
        else if (roll < 50)
            add_row(($urandom_range(1) == 1) ? CH_LBRACE : CH_RBRACE, 1'b0);
        else if (roll < 65)
        begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++)
                add_row(($urandom_range(4) == 0) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR)),
                        1'b0);
        end
        else if (roll < 73)
        begin
            add_row(CH_SLASH, 1'b0);
            add_row(CH_SLASH, 1'b0);
            len = $urandom_range(0, 8);
            for (int i = 0; i < len; i++)
            begin
                do
                    b = 8'($urandom);
                while (b == CH_LF);
                add_row(b, 1'b0);
            end
            if ($urandom_range(6) != 0)
                add_row(CH_LF, 1'b0);
        end
        else if (roll < 79)
        begin
            // lone slash, sometimes closed by the end marker while held
            add_row(CH_SLASH, 1'b0);
            add_row(8'($urandom), ($urandom_range(2) == 0));
        end
        else if (roll < 85)
            add_row(8'($urandom), 1'b1);
        else
        begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++)
                add_row(8'($urandom), ($urandom_range(19) == 0));
        end
    endtask

    task automatic flag_mismatch(string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%s", msg);
    endtask

    // prediction on each accepted request, check on each accepted result
    always @(posedge clk)
    begin
        int      n;
        result_t p0;
        result_t p1;
        result_t got;
        result_t want;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            classify_byte(in_ch.in_byte, in_ch.end_marker, n, p0, p1);
            if (cur_req.typed)
            begin
                n  = cur_req.n_typed;
                p0 = cur_req.t0;
                p1 = cur_req.t1;
            end
            if (n > 0)
                pending_tokens.push_back(p0);
            if (n > 1)
                pending_tokens.push_back(p1);
        end
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.out_byte    = out_ch.out_byte;
            got.role        = role_t'(out_ch.role);
            got.token_first = out_ch.token_first;
            got.last_of_run = out_ch.last_of_run;
            if (pending_tokens.size() == 0)
                flag_mismatch($sformatf("unexpected result: byte %h role %0d first %b last %b",
                                        got.out_byte, got.role, got.token_first, got.last_of_run));
            else
            begin
                want = pending_tokens.pop_front();
                if (got !== want)
                    flag_mismatch($sformatf(
                        "mismatch: expected byte %h role %0d first %b last %b, got byte %h role %0d first %b last %b",
                        want.out_byte, want.role, want.token_first, want.last_of_run,
                        got.out_byte, got.role, got.token_first, got.last_of_run));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ch.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial
    begin
        in_ch.valid      = 1'b0;
        in_ch.in_byte    = 8'h00;
        in_ch.end_marker = 1'b0;
        rst_n            = 1'b0;
        scan_state       = M_BETWEEN;
        mismatches       = 0;
        stall_cycles     = 0;
        send_idle        = 15;
        recv_idle        = 88;
        cur_req          = '{default: '0};

        // directed table: extremes, every role, held slash, escape and end marker cases
        add_typed("a",       1'b0, 1, tok("a", ROLE_WORD, 1'b1, 1'b1), '0);
        add_typed(8'hFF,     1'b0, 1, tok(8'hFF, ROLE_WORD, 1'b0, 1'b1), '0);
        add_typed(CH_SPACE,  1'b0, 1, tok(CH_SPACE, ROLE_SKIP, 1'b0, 1'b1), '0);
        add_typed(8'h00,     1'b0, 1, tok(8'h00, ROLE_WORD, 1'b1, 1'b1), '0);
        add_typed(CH_LBRACE, 1'b0, 1, tok(CH_LBRACE, ROLE_OPENB, 1'b1, 1'b1), '0);
        add_typed(CH_RBRACE, 1'b0, 1, tok(CH_RBRACE, ROLE_CLOSEB, 1'b1, 1'b1), '0);
        add_typed(CH_QUOTE,  1'b0, 1, tok(CH_QUOTE, ROLE_OPENQ, 1'b1, 1'b1), '0);
        add_row("x",         1'b0);
        add_row(CH_BSLASH,   1'b0);
        add_row(CH_QUOTE,    1'b0);
        add_row(CH_QUOTE,    1'b0);
        add_typed(CH_SLASH,  1'b0, 0, '0, '0);
        add_typed(CH_SLASH,  1'b0, 2, tok(CH_SLASH, ROLE_SKIP, 1'b0, 1'b0),
                  tok(CH_SLASH, ROLE_SKIP, 1'b0, 1'b1));
        add_row("q",         1'b0);
        add_row(CH_LF,       1'b0);
        add_row(CH_SLASH,    1'b0);
        add_row("k",         1'b0);
        add_row(CH_QUOTE,    1'b0);
        add_row(CH_SLASH,    1'b0);
        add_row(CH_CR,       1'b0);
        add_row(CH_SLASH,    1'b0);
        add_typed(8'h00,     1'b1, 2, tok(CH_SLASH, ROLE_WORD, 1'b1, 1'b0),
                  tok(8'h00, ROLE_END, 1'b0, 1'b1));
        add_row(CH_QUOTE,    1'b0);
        add_row(CH_BSLASH,   1'b0);
        add_typed(8'hFF,     1'b1, 1, tok(8'h00, ROLE_END, 1'b0, 1'b1), '0);
        add_row(CH_SLASH,    1'b0);
        add_row(CH_LBRACE,   1'b0);
        n_directed = text_q.size();

        while (text_q.size() < n_directed + RANDOM_ITEMS)
            add_random_chunk();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < text_q.size(); i++)
        begin
            if (i == n_directed + PHASE_ITEMS)
            begin
                send_idle = 88;
                recv_idle = 15;
            end
            else if (i == n_directed + 2 * PHASE_ITEMS)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            @(negedge clk);
            while ($urandom_range(99) < send_idle)
            begin
                in_ch.valid <= 1'b0;
                @(negedge clk);
            end
            cur_req = text_q[i];
            in_ch.valid      <= 1'b1;
            in_ch.in_byte    <= cur_req.b;
            in_ch.end_marker <= cur_req.eom;
            @(posedge clk);
            while (!in_ch.ready)
                @(posedge clk);
        end
        @(negedge clk);
        in_ch.valid <= 1'b0;

        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
